// File: rtl/dkc_pkg.sv
// Package for the k-mer counter: character codes, field widths, item kinds,
// the base decoder and the count-table operation codes.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package dkc_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned TEXT_W      = 8;
  localparam int unsigned KMER_CODE_W = 16;
  localparam int unsigned DUMP_IDX_W  = 16;
  localparam int unsigned WL_W        = 4;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned REG_IDX_W   = PADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_WORD_LENGTH = '0;

  // Smallest legal word length.
  localparam logic [WL_W-1:0] WL_MIN = 4'd2;

  // Item kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_DUMP = 1'b1;

  // Characters of interest.
  localparam logic [TEXT_W-1:0] CH_A_UC = 8'h41;
  localparam logic [TEXT_W-1:0] CH_A_LC = 8'h61;
  localparam logic [TEXT_W-1:0] CH_C_UC = 8'h43;
  localparam logic [TEXT_W-1:0] CH_C_LC = 8'h63;
  localparam logic [TEXT_W-1:0] CH_G_UC = 8'h47;
  localparam logic [TEXT_W-1:0] CH_G_LC = 8'h67;
  localparam logic [TEXT_W-1:0] CH_T_UC = 8'h54;
  localparam logic [TEXT_W-1:0] CH_T_LC = 8'h74;
  localparam logic [TEXT_W-1:0] CH_N_UC = 8'h4E;
  localparam logic [TEXT_W-1:0] CH_N_LC = 8'h6E;
  localparam logic [TEXT_W-1:0] CH_GT   = 8'h3E;
  localparam logic [TEXT_W-1:0] CH_LF   = 8'h0A;

  // Two-bit base codes.
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // Operation carried by the read-modify-write stage.
  typedef enum logic {
    OP_INC  = 1'b0,
    OP_DUMP = 1'b1
  } op_e;

  typedef struct packed {
    logic       hit;
    logic [1:0] code;
  } base_t;

  // Maps a text byte to its base code; hit is low for anything else.
  function automatic base_t base_decode(logic [TEXT_W-1:0] ch);
    base_t b;
    b.hit  = 1'b1;
    b.code = BASE_A;
    unique case (ch) inside
      CH_A_UC, CH_A_LC: b.code = BASE_A;
      CH_C_UC, CH_C_LC: b.code = BASE_C;
      CH_G_UC, CH_G_LC: b.code = BASE_G;
      CH_T_UC, CH_T_LC: b.code = BASE_T;
      default:          b.hit  = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dkc_if.sv
// Valid/ready channel interfaces of the k-mer counter: text/dump items in,
// dumped table entries out. Depends on dkc_pkg for the field widths.
`default_nettype none

interface dkc_in_if
  import dkc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TEXT_W-1:0] text_byte;

  modport source (output valid, kind, text_byte, input ready);
  modport sink   (input valid, kind, text_byte, output ready);
endinterface

interface dkc_out_if
  import dkc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [KMER_CODE_W-1:0] kmer_code;
  logic [COUNT_WIDTH-1:0] occurrences;
  logic                   last_entry;

  modport source (output valid, kmer_code, occurrences, last_entry, input ready);
  modport sink   (input valid, kmer_code, occurrences, last_entry, output ready);
endinterface

`default_nettype wire

// File: rtl/dna_kmer_counter.sv
// Top level of the k-mer counter: text decoder, rolling window, count table
// memory with its read-modify-write stage, dump walker and APB register.
// Depends on dkc_pkg and the channel interfaces in dkc_if.sv.
`default_nettype none

// The block takes one beat per clock cycle unless stalled, text bytes and dump
// steps alike, in any mix. A counted base or a dump step reads its count-table
// entry in the cycle it is accepted, then writes it back; the write is
// forwarded to the next access of the same entry, so the single table memory
// sustains one read-modify-write per cycle. Results leave through an output
// register, and the input stalls only while a dump result is held there
// waiting to be taken. After reset the table is cleared one entry per cycle,
// 4**MAX_WORD entries (65536 at the default size), and no beat is accepted
// until that pass is done; the word_length register can be written meanwhile.
module dna_kmer_counter
  import dkc_pkg::*;
#(
  parameter int unsigned MAX_WORD    = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  dkc_in_if.sink                in_i,
  dkc_out_if.source             out_o,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [PADDR_W-1:0]    paddr,
  input  wire  [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W  = 2 * MAX_WORD;
  localparam int unsigned DEPTH  = 1 << IDX_W;
  localparam int unsigned DUMP_W = (IDX_W < DUMP_IDX_W) ? IDX_W : DUMP_IDX_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [WL_W-1:0] WL_MAX   = WL_W'(MAX_WORD);
  localparam logic [WL_W-1:0] WL_RESET = (MAX_WORD < 8) ? WL_W'(MAX_WORD) : WL_W'(8);

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] addr;
    logic             last;
  } rmw_t;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [WL_W-1:0]      wl_q;
  logic [WL_W-1:0]      wl_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Out-of-range word lengths in pwdata[WL_W-1:0] are clamped on write.
  always_comb begin
    wl_wr = pwdata[WL_W-1:0];
    if (wl_wr < WL_MIN) begin
      wl_wr = WL_MIN;
    end else if (wl_wr > WL_MAX) begin
      wl_wr = WL_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
    end else if (cfg_wr && (reg_idx == REG_WORD_LENGTH)) begin
      wl_q <= wl_wr;
    end
  end

  assign prdata = (reg_idx == REG_WORD_LENGTH) ? APB_DATA_W'(wl_q) : '0;

  // Word mask: the low 2*k bits.
  logic [IDX_W-1:0] mask;
  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (i < 2 * int'(wl_q));
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic                   clearing_q;
  logic [IDX_W-1:0]       clr_addr_q;
  logic                   s1_valid_q;
  rmw_t                   s1_q;
  logic                   s1_res;
  logic                   s1_adv;
  logic                   s1_fire;
  logic                   out_valid_q;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] old_cnt;

  assign s1_adv     = !s1_res || !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------
  // Decode stage: window, header skip and dump walker
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  window_q, window_d;
  logic [WL_W-1:0]   filled_q, filled_d;
  logic              skip_q, skip_d;
  logic [DUMP_W-1:0] dump_q, dump_d;
  logic              issue;
  rmw_t              rmw;
  base_t             base;
  logic [IDX_W-1:0]  win_shift;
  logic [IDX_W-1:0]  dump_addr;

  assign base      = base_decode(in_i.text_byte);
  assign win_shift = {window_q[IDX_W-3:0], base.code} & mask;
  assign dump_addr = IDX_W'(dump_q) & mask;

  always_comb begin
    window_d = window_q;
    filled_d = filled_q;
    skip_d   = skip_q;
    dump_d   = dump_q;
    issue    = 1'b0;
    rmw.op   = OP_INC;
    rmw.addr = win_shift;
    rmw.last = 1'b0;
    if (accept) begin
      if (in_i.kind == KIND_DUMP) begin
        // Dump step: read and clear one entry, then advance or wrap.
        issue    = 1'b1;
        rmw.op   = OP_DUMP;
        rmw.addr = dump_addr;
        rmw.last = (dump_addr == mask);
        dump_d   = rmw.last ? '0 : DUMP_W'(dump_addr + IDX_W'(1));
      end else if (skip_q) begin
        if (in_i.text_byte == CH_LF) begin
          skip_d = 1'b0;
        end
      end else if (in_i.text_byte == CH_GT) begin
        skip_d   = 1'b1;
        window_d = '0;
        filled_d = '0;
      end else if ((in_i.text_byte == CH_N_UC) || (in_i.text_byte == CH_N_LC)) begin
        window_d = '0;
        filled_d = '0;
      end else if (base.hit) begin
        window_d = win_shift;
        if (({1'b0, filled_q} + 5'd1) >= {1'b0, wl_q}) begin
          issue = 1'b1;
        end else begin
          filled_d = filled_q + WL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      filled_q <= '0;
      skip_q   <= 1'b0;
      dump_q   <= '0;
    end else begin
      window_q <= window_d;
      filled_q <= filled_d;
      skip_q   <= skip_d;
      dump_q   <= dump_d;
    end
  end

  // ---------------------------------------------------------------------
  // Count table memory
  // ---------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_q <= mem[rmw.addr];
    end
  end

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + IDX_W'(1);
      if (clr_addr_q == {IDX_W{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Read-modify-write stage
  // ---------------------------------------------------------------------
  logic                   wr_valid_q;
  logic [IDX_W-1:0]       wr_addr_q;
  logic [COUNT_WIDTH-1:0] wr_data_q;

  // The last write is forwarded; it always matches what the memory holds.
  assign old_cnt = (wr_valid_q && (wr_addr_q == s1_q.addr)) ? wr_data_q : rd_data_q;
  assign s1_res  = s1_valid_q && (s1_q.op == OP_DUMP) && ((old_cnt != '0) || s1_q.last);

  always_comb begin
    mem_we    = clearing_q || s1_fire;
    mem_waddr = clearing_q ? clr_addr_q : s1_q.addr;
    mem_wdata = '0;
    if (!clearing_q && (s1_q.op == OP_INC)) begin
      mem_wdata = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (mem_we) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= rmw;
    end
    if (mem_we) begin
      wr_addr_q <= mem_waddr;
      wr_data_q <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_res) begin
      out_o.kmer_code   <= KMER_CODE_W'(s1_q.addr);
      out_o.occurrences <= old_cnt;
      out_o.last_entry  <= s1_q.last;
    end
  end

  assign out_o.valid = out_valid_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`ifndef SYNTHESIS
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_i.ready)
    else $error("beat accepted during table clearing");

  a_no_rmw_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_valid_q)
    else $error("table access pending during clearing");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_addr_q) == {IDX_W{1'b1}}))
    else $error("clearing pass ended early");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_res && out_valid_q && !out_o.ready) |=> (s1_valid_q && $stable(s1_q)))
    else $error("dump result dropped under backpressure");
`endif

endmodule

`default_nettype wire
